/* rtl/lfsq_pkg.sv */
// ----------------------------------------------------------------------------
// lfsq_pkg: shared types and constants for the largest free square finder
// Grid limits, field widths, register indexes and the evaluator structs.
// ----------------------------------------------------------------------------
package lfsq_pkg;

	// grid limits
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;

	// field widths
	localparam int COL_W   = 10;
	localparam int ROW_W   = 10;
	localparam int SIDE_W  = 11;
	localparam int DIM_W   = 11;
	localparam int CFG_IDX_W = 8;

	// line buffer address width
	localparam int LINE_AW = $clog2(MAX_COLS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);

	// neighbor values and running best seen by the cell evaluator
	typedef struct packed {
		logic              cell_free;
		logic [SIDE_W-1:0] right;
		logic [SIDE_W-1:0] below;
		logic [SIDE_W-1:0] below_right;
		logic [SIDE_W-1:0] best_side;
	} lfsq_nbr_t;

	// evaluator result: square side at this cell and best-update flag
	typedef struct packed {
		logic [SIDE_W-1:0] value;
		logic              take;
	} lfsq_eval_t;

	// clamp a configured dimension into 1..max
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
	                                               input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* rtl/lfsq_if.sv */
// ----------------------------------------------------------------------------
// lfsq_if: channel interfaces for the largest free square finder
// Cell input stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------

// cell stream, one grid cell per item
interface lfsq_cell_if;
	logic valid;
	logic ready;
	logic cell_free;

	modport source (output valid, output cell_free, input ready);
	modport sink (input valid, input cell_free, output ready);
endinterface

// result stream, one item per finished grid
interface lfsq_result_if;
	logic                      valid;
	logic                      ready;
	logic [lfsq_pkg::SIDE_W-1:0] square_side;
	logic [lfsq_pkg::ROW_W-1:0]  top_row;
	logic [lfsq_pkg::COL_W-1:0]  left_col;

	modport source (output valid, output square_side, output top_row, output left_col,
		input ready);
	modport sink (input valid, input square_side, input top_row, input left_col,
		output ready);
endinterface

// configuration register writes
interface lfsq_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lfsq_pkg::CFG_IDX_W-1:0] index;
	logic [lfsq_pkg::DIM_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/lfsq_ram.sv */
// ----------------------------------------------------------------------------
// lfsq_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; read returns old data on collision.
// ----------------------------------------------------------------------------
module lfsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/lfsq_eval.sv */
// ----------------------------------------------------------------------------
// lfsq_eval: per-cell square side evaluator
// Side = 1 + min of right, below and below-right for a free cell, else 0.
// ----------------------------------------------------------------------------
module lfsq_eval (
	input  lfsq_pkg::lfsq_nbr_t  nbr,
	output lfsq_pkg::lfsq_eval_t res
);

	logic [lfsq_pkg::SIDE_W-1:0] min_rb;
	logic [lfsq_pkg::SIDE_W-1:0] min_all;

	// minimum of the three neighbors
	always_comb begin
		min_rb  = (nbr.right < nbr.below) ? nbr.right : nbr.below;
		min_all = (min_rb < nbr.below_right) ? min_rb : nbr.below_right;
	end

	// side at this cell; equal sides replace the best to favor top then left
	always_comb begin
		res.value = nbr.cell_free ? min_all + lfsq_pkg::SIDE_W'(1) : '0;
		res.take  = (res.value != '0) && (res.value >= nbr.best_side);
	end

endmodule

/* rtl/largest_free_square.sv */
// ----------------------------------------------------------------------------
// largest_free_square: largest free square over a reverse raster cell stream
// The result item is valid in the cycle after the last cell is accepted.
// Throughput: one cell per cycle, set by the line buffer's one read and one write.
// A final cell waits only while the previous result has not been taken.
// Reset: asynchronous, clears scan position, neighbors and best square; grid
// size returns to 1024 by 1024. The line buffer needs no clearing.
// ----------------------------------------------------------------------------
module largest_free_square (
	input  logic           clk,
	input  logic           arst_n,
	lfsq_cell_if.sink      cells,
	lfsq_result_if.source  result,
	lfsq_cfg_if.sink       cfg
);

	localparam logic [lfsq_pkg::DIM_W-1:0] MAX_COLS_D = lfsq_pkg::DIM_W'(lfsq_pkg::MAX_COLS);
	localparam logic [lfsq_pkg::DIM_W-1:0] MAX_ROWS_D = lfsq_pkg::DIM_W'(lfsq_pkg::MAX_ROWS);

	logic [lfsq_pkg::DIM_W-1:0]  grid_cols_q, grid_rows_q;
	logic [lfsq_pkg::DIM_W-1:0]  cols_eff, rows_eff;
	logic [lfsq_pkg::COL_W-1:0]  col_q, col_d;
	logic [lfsq_pkg::ROW_W-1:0]  row_q;
	logic [lfsq_pkg::SIDE_W-1:0] right_q, below_right_q;
	logic [lfsq_pkg::SIDE_W-1:0] best_side_q;
	logic [lfsq_pkg::ROW_W-1:0]  best_row_q;
	logic [lfsq_pkg::COL_W-1:0]  best_col_q;
	logic                        fwd_q;
	logic [lfsq_pkg::SIDE_W-1:0] fwd_data_q;
	logic                        out_valid_q;
	logic [lfsq_pkg::SIDE_W-1:0] out_side_q;
	logic [lfsq_pkg::ROW_W-1:0]  out_row_q;
	logic [lfsq_pkg::COL_W-1:0]  out_col_q;

	logic                        accept, cfg_wr, cfg_hit;
	logic                        first_col, bottom_row, last_col, last_row, last_cell;
	logic [lfsq_pkg::SIDE_W-1:0] rd_data, below_raw, below;
	logic [lfsq_pkg::SIDE_W-1:0] new_side;
	logic [lfsq_pkg::ROW_W-1:0]  new_row;
	logic [lfsq_pkg::COL_W-1:0]  new_col;
	lfsq_pkg::lfsq_nbr_t         nbr;
	lfsq_pkg::lfsq_eval_t        ev;

	// effective grid size
	assign cols_eff = lfsq_pkg::clamp_dim(grid_cols_q, MAX_COLS_D);
	assign rows_eff = lfsq_pkg::clamp_dim(grid_rows_q, MAX_ROWS_D);

	// scan position flags
	assign first_col  = (col_q == '0);
	assign bottom_row = (row_q == '0);
	assign last_col   = ({1'b0, col_q} == cols_eff - lfsq_pkg::DIM_W'(1));
	assign last_row   = ({1'b0, row_q} == rows_eff - lfsq_pkg::DIM_W'(1));
	assign last_cell  = last_col && last_row;

	// handshakes: only a final cell waits on a pending result
	assign cells.ready = !(last_cell && out_valid_q && !result.ready);
	assign accept      = cells.valid && cells.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_wr      = cfg.valid;
	assign cfg_hit     = cfg_wr && ((cfg.index == lfsq_pkg::REG_GRID_COLS) ||
		(cfg.index == lfsq_pkg::REG_GRID_ROWS));

	// next column, also the line buffer read address for the next item
	always_comb begin
		col_d = col_q;
		if (cfg_hit) begin
			col_d = '0;
		end else if (accept) begin
			col_d = last_col ? '0 : col_q + lfsq_pkg::COL_W'(1);
		end
	end

	// line of side values for the row below
	lfsq_ram #(
		.WIDTH (lfsq_pkg::SIDE_W),
		.DEPTH (lfsq_pkg::MAX_COLS)
	) u_line (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (lfsq_pkg::LINE_AW'(col_q)),
		.wr_data (ev.value),
		.rd_addr (lfsq_pkg::LINE_AW'(col_d)),
		.rd_data (rd_data)
	);

	// neighbor selection; one-column grids forward the last written value
	always_comb begin
		below_raw       = fwd_q ? fwd_data_q : rd_data;
		below           = bottom_row ? '0 : below_raw;
		nbr.cell_free   = cells.cell_free;
		nbr.right       = first_col ? '0 : right_q;
		nbr.below       = below;
		nbr.below_right = first_col ? '0 : below_right_q;
		nbr.best_side   = best_side_q;
	end

	lfsq_eval u_eval (
		.nbr (nbr),
		.res (ev)
	);

	// best square including the current cell
	always_comb begin
		new_side = best_side_q;
		new_row  = best_row_q;
		new_col  = best_col_q;
		if (ev.take) begin
			new_side = ev.value;
			new_row  = lfsq_pkg::ROW_W'(rows_eff - lfsq_pkg::DIM_W'(1) - {1'b0, row_q});
			new_col  = lfsq_pkg::COL_W'(cols_eff - lfsq_pkg::DIM_W'(1) - {1'b0, col_q});
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= MAX_COLS_D;
			grid_rows_q <= MAX_ROWS_D;
		end else if (cfg_wr) begin
			if (cfg.index == lfsq_pkg::REG_GRID_COLS) begin
				grid_cols_q <= cfg.data;
			end
			if (cfg.index == lfsq_pkg::REG_GRID_ROWS) begin
				grid_rows_q <= cfg.data;
			end
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			right_q       <= '0;
			below_right_q <= '0;
			best_side_q   <= '0;
			best_row_q    <= '0;
			best_col_q    <= '0;
			fwd_q         <= 1'b0;
		end else begin
			col_q <= col_d;
			fwd_q <= 1'b0;
			if (cfg_hit) begin
				row_q         <= '0;
				right_q       <= '0;
				below_right_q <= '0;
				best_side_q   <= '0;
				best_row_q    <= '0;
				best_col_q    <= '0;
			end else if (accept) begin
				right_q       <= ev.value;
				below_right_q <= below;
				fwd_q         <= first_col && last_col;
				if (last_cell) begin
					row_q       <= '0;
					best_side_q <= '0;
					best_row_q  <= '0;
					best_col_q  <= '0;
				end else begin
					if (last_col) begin
						row_q <= row_q + lfsq_pkg::ROW_W'(1);
					end
					best_side_q <= new_side;
					best_row_q  <= new_row;
					best_col_q  <= new_col;
				end
			end
		end
	end

	// forwarded side value
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_data_q <= ev.value;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_cell) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_cell) begin
			out_side_q <= new_side;
			out_row_q  <= new_row;
			out_col_q  <= new_col;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.square_side = out_side_q;
	assign result.top_row     = out_row_q;
	assign result.left_col    = out_col_q;

`ifndef SYNTH
	// forwarding only happens on one-column grids
	a_fwd_one_col: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> (cols_eff == lfsq_pkg::DIM_W'(1)))
		else $error("line forward outside a one-column grid");

	// a final cell always produces a result item
	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_cell) |=> out_valid_q)
		else $error("final cell gave no result item");

	// the input only stalls behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cells.ready |-> (out_valid_q && last_cell))
		else $error("input stalled without a pending result");

	// end of row moves to the next row at column zero
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_hit && last_col && !last_row) |=>
		((col_q == '0) && (row_q == $past(row_q) + lfsq_pkg::ROW_W'(1))))
		else $error("row advance failed");
`endif

endmodule
